[sv/fcbf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fcbf_pkg
// Shared types and constants of the flow-controlled byte FIFO.
// ----------------------------------------------------------------------------
package fcbf_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;

  localparam int unsigned ACT_W  = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned TOT_W  = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  // action field codes
  localparam logic [ACT_W-1:0] ACT_WRITE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_END   = 3'd4;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_PEEK,
    OP_POP,
    OP_END,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
    logic              last;
    logic              write_accepted;
    logic [CNT_W-1:0]  fill_count;
    logic [CNT_W-1:0]  space_left;
    logic              input_closed;
    logic              stream_done;
    logic [TOT_W-1:0]  total_written;
    logic [TOT_W-1:0]  total_read;
  } result_t;

endpackage
`default_nettype wire

[sv/fcbf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fcbf_front
// Accepts input items, decodes the action and holds them in a two-entry
// command queue for the back end.
// ----------------------------------------------------------------------------
module fcbf_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [fcbf_pkg::ACT_W-1:0]  action_i,
  input  wire logic [fcbf_pkg::BYTE_W-1:0] data_byte_i,
  input  wire logic [fcbf_pkg::LEN_W-1:0]  length_i,
  output logic                          cmd_valid_o,
  output fcbf_pkg::cmd_t                cmd_o,
  input  wire logic                     cmd_pop_i
);
  import fcbf_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;
  op_e        op;

  always_comb begin
    unique case (action_i)
      ACT_WRITE: op = OP_WRITE;
      ACT_READ:  op = OP_READ;
      ACT_PEEK:  op = OP_PEEK;
      ACT_POP:   op = OP_POP;
      ACT_END:   op = OP_END;
      default:   op = OP_NONE;
    endcase
  end

  assign full        = (count_q == 2'd2);
  assign do_push     = push && !full;
  assign cmd_valid_o = (count_q != 2'd0);
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= '{op: op, data: data_byte_i, len: length_i};
    end
  end

endmodule
`default_nettype wire

[sv/fcbf_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fcbf_back
// Executes commands against the ring buffer and produces result items.
// Holds the byte memory, pointers, fill count, totals and capacity register.
// ----------------------------------------------------------------------------
module fcbf_back #(
  parameter int unsigned DEPTH = fcbf_pkg::DEPTH_DEFAULT
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [fcbf_pkg::CNT_W-1:0] cfg_data_i,
  input  wire logic                       cmd_valid_i,
  input  wire fcbf_pkg::cmd_t             cmd_i,
  output logic                            cmd_pop_o,
  input  wire logic                       res_full_i,
  output logic                            res_push_o,
  output fcbf_pkg::result_t               res_o
);
  import fcbf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0]    PTR_LAST = PW'(DEPTH - 1);
  localparam logic [7:0]       DEPTH_W  = 8'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RD   = 1'b1;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  logic             st_q, st_d;
  logic [PW-1:0]    rp_q, rp_d;
  logic [PW-1:0]    pos_q, pos_d, pos_next;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             is_read_q, is_read_d;
  logic             ended_q, ended_d;
  logic [TOT_W-1:0] wt_q, wt_d;
  logic [TOT_W-1:0] rt_q, rt_d;
  logic [CNT_W-1:0] cap_q, eff_cap;

  logic [CNT_W-1:0] n_avail;
  logic [7:0]       waddr_sum, pop_sum;
  logic [PW-1:0]    waddr, pop_ptr, raddr;
  logic             mem_we, wr_ok;
  logic             room;
  logic             r_valid, r_acc;
  logic [BYTE_W-1:0] r_byte;

  assign room    = !res_full_i;
  assign eff_cap = (cap_q > DEPTH_C) ? DEPTH_C : cap_q;
  assign n_avail = (cmd_i.len < occ_q) ? cmd_i.len : occ_q;
  assign wr_ok   = !ended_q && (occ_q < eff_cap);

  // both sums stay below twice the depth: one conditional subtract wraps them
  assign waddr_sum = 8'(rp_q) + 8'(occ_q);
  assign waddr     = PW'((waddr_sum >= DEPTH_W) ? waddr_sum - DEPTH_W : waddr_sum);
  assign pop_sum   = 8'(rp_q) + 8'(n_avail);
  assign pop_ptr   = PW'((pop_sum >= DEPTH_W) ? pop_sum - DEPTH_W : pop_sum);
  assign pos_next  = (pos_q == PTR_LAST) ? '0 : pos_q + PW'(1);

  always_comb begin
    st_d      = st_q;
    rp_d      = rp_q;
    pos_d     = pos_q;
    occ_d     = occ_q;
    cnt_d     = cnt_q;
    is_read_d = is_read_q;
    ended_d   = ended_q;
    wt_d      = wt_q;
    rt_d      = rt_q;
    mem_we    = 1'b0;
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    r_valid   = 1'b0;
    r_acc     = 1'b0;
    r_byte    = '0;
    raddr     = rp_q;

    unique case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i && room) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_WRITE: begin
              res_push_o = 1'b1;
              if (wr_ok) begin
                mem_we = 1'b1;
                occ_d  = occ_q + CNT_W'(1);
                wt_d   = wt_q + TOT_W'(1);
                r_acc  = 1'b1;
              end
            end
            OP_READ, OP_PEEK: begin
              if (n_avail == '0) begin
                res_push_o = 1'b1;
              end else begin
                // start streaming; first byte lands in rdata_q next cycle
                st_d      = ST_RD;
                pos_d     = rp_q;
                cnt_d     = n_avail;
                is_read_d = (cmd_i.op == OP_READ);
              end
            end
            OP_POP: begin
              res_push_o = 1'b1;
              rp_d  = pop_ptr;
              occ_d = occ_q - n_avail;
              rt_d  = rt_q + TOT_W'(n_avail);
            end
            OP_END: begin
              res_push_o = 1'b1;
              ended_d    = 1'b1;
            end
            default: begin
              res_push_o = 1'b1;
            end
          endcase
        end
      end
      ST_RD: begin
        raddr = pos_q;
        if (room) begin
          res_push_o = 1'b1;
          r_valid    = 1'b1;
          r_byte     = rdata_q;
          raddr      = pos_next;
          pos_d      = pos_next;
          cnt_d      = cnt_q - CNT_W'(1);
          if (is_read_q) begin
            rp_d  = pos_next;
            occ_d = occ_q - CNT_W'(1);
            rt_d  = rt_q + TOT_W'(1);
          end
          if (cnt_q == CNT_W'(1)) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // status fields always reflect the state after this result
  always_comb begin
    res_o.data_out       = r_byte;
    res_o.data_valid     = r_valid;
    res_o.last           = !r_valid || (cnt_q == CNT_W'(1));
    res_o.write_accepted = r_acc;
    res_o.fill_count     = occ_d;
    res_o.space_left     = (eff_cap > occ_d) ? eff_cap - occ_d : '0;
    res_o.input_closed   = ended_d;
    res_o.stream_done    = ended_d && (occ_d == '0);
    res_o.total_written  = wt_d;
    res_o.total_read     = rt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      rp_q      <= '0;
      pos_q     <= '0;
      occ_q     <= '0;
      cnt_q     <= '0;
      is_read_q <= 1'b0;
      ended_q   <= 1'b0;
      wt_q      <= '0;
      rt_q      <= '0;
      cap_q     <= CAP_RESET;
    end else begin
      st_q      <= st_d;
      rp_q      <= rp_d;
      pos_q     <= pos_d;
      occ_q     <= occ_d;
      cnt_q     <= cnt_d;
      is_read_q <= is_read_d;
      ended_q   <= ended_d;
      wt_q      <= wt_d;
      rt_q      <= rt_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= cmd_i.data;
    end
    rdata_q <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/fcbf_res_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fcbf_res_queue
// Two-entry result queue that decouples the back end from the consumer.
// ----------------------------------------------------------------------------
module fcbf_res_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_i,
  input  wire fcbf_pkg::result_t wdata_i,
  output logic                   full_o,
  output logic                   empty,
  input  wire logic              pop,
  output fcbf_pkg::result_t      rdata_o
);
  import fcbf_pkg::*;

  result_t    entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_wr, do_rd;

  assign full_o  = (count_q == 2'd2);
  assign empty   = (count_q == 2'd0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = pop && !empty;
  assign rdata_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_q <= !wr_ptr_q;
      if (do_rd) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

[sv/flow_controlled_byte_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// flow_controlled_byte_fifo
// Bounded byte FIFO with capacity limit, end-of-input and status results.
// ----------------------------------------------------------------------------
// Items enter through a queue interface (push/full) and results leave through
// another (empty/pop); a two-entry command queue and a two-entry result queue
// let each side stall on its own. Write, pop, end-input and unknown actions
// each give one result. A read or peek gives one result per delivered byte,
// min(length, fill) of them after a setup step, or one if it finds nothing;
// bytes are paced by the single read port of the byte memory, and no new
// command is taken until the last is out. Every result carries the status
// after its own effect. The user must write the capacity register over the
// cfg_valid_i/cfg_ready_o channel only while idle; the block does not check.
module flow_controlled_byte_fifo #(
  parameter int unsigned DEPTH = fcbf_pkg::DEPTH_DEFAULT
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [6:0] cfg_data_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [2:0] action_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [6:0] length_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      data_out_o,
  output logic            data_valid_o,
  output logic            last_o,
  output logic            write_accepted_o,
  output logic [6:0]      fill_count_o,
  output logic [6:0]      space_left_o,
  output logic            input_closed_o,
  output logic            stream_done_o,
  output logic [31:0]     total_written_o,
  output logic [31:0]     total_read_o
);
  import fcbf_pkg::*;

  cmd_t    cmd;
  logic    cmd_valid, cmd_pop;
  result_t res_in, res_out;
  logic    res_push, res_full;

  assign cfg_ready_o = 1'b1;

  fcbf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .length_i    (length_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  fcbf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  fcbf_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .empty   (empty),
    .pop     (pop),
    .rdata_o (res_out)
  );

  assign data_out_o       = res_out.data_out;
  assign data_valid_o     = res_out.data_valid;
  assign last_o           = res_out.last;
  assign write_accepted_o = res_out.write_accepted;
  assign fill_count_o     = res_out.fill_count;
  assign space_left_o     = res_out.space_left;
  assign input_closed_o   = res_out.input_closed;
  assign stream_done_o    = res_out.stream_done;
  assign total_written_o  = res_out.total_written;
  assign total_read_o     = res_out.total_read;

endmodule
`default_nettype wire

[verif/tb_flow_controlled_byte_fifo.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_flow_controlled_byte_fifo
// Self-checking bench for the flow-controlled byte FIFO.
// ----------------------------------------------------------------------------
// A clocked driver feeds commands from a pending queue; a clocked monitor pops
// results and compares every field against a shadow copy of the buffer
// contents, counters and flags. Phases move the capacity register through
// zero, one, small, full depth, out-of-range and lowered-below-fill values.
// One phase holds the result side off long enough to back up the input, and
// the run ends by closing input and draining what is left.
// ----------------------------------------------------------------------------
module tb_flow_controlled_byte_fifo;
  import fcbf_pkg::*;

  localparam int unsigned RUN_LIMIT      = 10_000_000;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned PTR_W          = $clog2(DEPTH_DEFAULT);

  // action codes the block treats as no-ops
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
  localparam logic [LEN_W-1:0] LEN_MAX      = 7'd127;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } fifo_cmd_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CNT_W-1:0]  cfg_data_i  = '0;
  logic              push        = 1'b0;
  logic              full;
  logic [ACT_W-1:0]  action_i    = ACT_WRITE;
  logic [BYTE_W-1:0] data_byte_i = '0;
  logic [LEN_W-1:0]  length_i    = '0;
  logic              empty;
  logic              pop         = 1'b0;
  logic [BYTE_W-1:0] data_out_o;
  logic              data_valid_o;
  logic              last_o;
  logic              write_accepted_o;
  logic [CNT_W-1:0]  fill_count_o;
  logic [CNT_W-1:0]  space_left_o;
  logic              input_closed_o;
  logic              stream_done_o;
  logic [TOT_W-1:0]  total_written_o;
  logic [TOT_W-1:0]  total_read_o;

  // shadow of the FIFO
  logic [BYTE_W-1:0] shadow_bytes [DEPTH_DEFAULT];
  logic [PTR_W-1:0]  shadow_head     = '0;
  logic [CNT_W-1:0]  shadow_fill     = '0;
  logic              shadow_closed   = 1'b0;
  logic [TOT_W-1:0]  shadow_wr_total = '0;
  logic [TOT_W-1:0]  shadow_rd_total = '0;
  logic [CNT_W-1:0]  shadow_cap      = CAP_RESET;

  fifo_cmd_t   pending_cmds [$];
  result_t     due_results  [$];
  fifo_cmd_t   offer_cmd;

  int unsigned send_gap      = 0;
  int unsigned recv_gap      = 0;
  int unsigned squeeze_left  = 0;
  bit          squeeze_req   = 1'b0;
  bit          squeeze_taken = 1'b0;
  bit          burst_mode    = 1'b0;
  int unsigned mismatches    = 0;
  int unsigned cmds_taken    = 0;
  int unsigned results_seen  = 0;
  int unsigned bytes_seen    = 0;
  int unsigned cfg_writes    = 0;
  int unsigned cycle_count   = 0;

  flow_controlled_byte_fifo u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .action_i         (action_i),
    .data_byte_i      (data_byte_i),
    .length_i         (length_i),
    .empty            (empty),
    .pop              (pop),
    .data_out_o       (data_out_o),
    .data_valid_o     (data_valid_o),
    .last_o           (last_o),
    .write_accepted_o (write_accepted_o),
    .fill_count_o     (fill_count_o),
    .space_left_o     (space_left_o),
    .input_closed_o   (input_closed_o),
    .stream_done_o    (stream_done_o),
    .total_written_o  (total_written_o),
    .total_read_o     (total_read_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [CNT_W-1:0] usable_capacity();
    return (shadow_cap > CNT_W'(DEPTH_DEFAULT)) ? CNT_W'(DEPTH_DEFAULT) : shadow_cap;
  endfunction

  function automatic result_t status_word(logic [BYTE_W-1:0] b, logic valid, logic fin,
                                          logic acc);
    result_t          r;
    logic [CNT_W-1:0] cap;
    cap              = usable_capacity();
    r.data_out       = valid ? b : '0;
    r.data_valid     = valid;
    r.last           = fin;
    r.write_accepted = acc;
    r.fill_count     = shadow_fill;
    r.space_left     = (cap > shadow_fill) ? cap - shadow_fill : '0;
    r.input_closed   = shadow_closed;
    r.stream_done    = shadow_closed && (shadow_fill == '0);
    r.total_written  = shadow_wr_total;
    r.total_read     = shadow_rd_total;
    return r;
  endfunction

  // Advance the shadow by one command and queue the results it causes.
  task automatic apply_command(fifo_cmd_t c);
    logic [CNT_W-1:0]  n;
    logic [PTR_W-1:0]  pos;
    logic [BYTE_W-1:0] b;
    int                i;
    n = (c.len < shadow_fill) ? c.len : shadow_fill;
    case (c.act)
      ACT_WRITE: begin
        if (!shadow_closed && shadow_fill < usable_capacity()) begin
          pos               = shadow_head + shadow_fill[PTR_W-1:0];
          shadow_bytes[pos] = c.data;
          shadow_fill++;
          shadow_wr_total++;
          due_results.push_back(status_word('0, 1'b0, 1'b1, 1'b1));
        end else begin
          due_results.push_back(status_word('0, 1'b0, 1'b1, 1'b0));
        end
      end
      ACT_READ, ACT_PEEK: begin
        if (n == '0) begin
          due_results.push_back(status_word('0, 1'b0, 1'b1, 1'b0));
        end else begin
          pos = shadow_head;
          for (i = 0; i < int'(n); i++) begin
            b   = shadow_bytes[pos];
            pos = pos + PTR_W'(1);
            // a read shows the status after its own byte left
            if (c.act == ACT_READ) begin
              shadow_head = pos;
              shadow_fill--;
              shadow_rd_total++;
            end
            due_results.push_back(status_word(b, 1'b1, i == int'(n) - 1, 1'b0));
          end
        end
      end
      ACT_POP: begin
        shadow_head     = shadow_head + n[PTR_W-1:0];
        shadow_fill     = shadow_fill - n;
        shadow_rd_total = shadow_rd_total + TOT_W'(n);
        due_results.push_back(status_word('0, 1'b0, 1'b1, 1'b0));
      end
      ACT_END: begin
        shadow_closed = 1'b1;
        due_results.push_back(status_word('0, 1'b0, 1'b1, 1'b0));
      end
      default: begin
        due_results.push_back(status_word('0, 1'b0, 1'b1, 1'b0));
      end
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(12, 48);
  endfunction

  task automatic compare_field(string field, logic [TOT_W-1:0] want_v,
                               logic [TOT_W-1:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, want_v, got_v);
    end
  endtask

  // Driver: hold an offered command until the block takes it.
  always @(posedge clk_i) begin : driver
    logic      offer_free;
    fifo_cmd_t nxt;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      offer_free = !push;
      if (push && !full) begin
        apply_command(offer_cmd);
        cmds_taken++;
        offer_free = 1'b1;
        send_gap   = pick_gap();
      end
      if (offer_free) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          nxt         = pending_cmds.pop_front();
          offer_cmd   = nxt;
          push        <= 1'b1;
          action_i    <= nxt.act;
          data_byte_i <= nxt.data;
          length_i    <= nxt.len;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each popped result against the oldest one due.
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (data_valid_o === 1'b1) bytes_seen++;
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result mismatch, expected none, actual fill 0x%0h data 0x%0h",
                   $time, fill_count_o, data_out_o);
        end else begin
          want = due_results.pop_front();
          compare_field("data_out", TOT_W'(want.data_out), TOT_W'(data_out_o));
          compare_field("data_valid", TOT_W'(want.data_valid), TOT_W'(data_valid_o));
          compare_field("last", TOT_W'(want.last), TOT_W'(last_o));
          compare_field("write_accepted", TOT_W'(want.write_accepted),
                        TOT_W'(write_accepted_o));
          compare_field("fill_count", TOT_W'(want.fill_count), TOT_W'(fill_count_o));
          compare_field("space_left", TOT_W'(want.space_left), TOT_W'(space_left_o));
          compare_field("input_closed", TOT_W'(want.input_closed),
                        TOT_W'(input_closed_o));
          compare_field("stream_done", TOT_W'(want.stream_done), TOT_W'(stream_done_o));
          compare_field("total_written", want.total_written, total_written_o);
          compare_field("total_read", want.total_read, total_read_o);
        end
        recv_gap = pick_gap();
      end
      if (squeeze_req && !squeeze_taken) begin
        squeeze_taken = 1'b1;
        squeeze_left  = SQUEEZE_CYCLES;
      end
      if (squeeze_left > 0) begin
        squeeze_left--;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t ns: timeout, %0d results outstanding, %0d commands pending",
             $time, due_results.size(), pending_cmds.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic queue_cmd(logic [ACT_W-1:0] a, logic [BYTE_W-1:0] d,
                           logic [LEN_W-1:0] l);
    fifo_cmd_t c;
    c.act  = a;
    c.data = d;
    c.len  = l;
    pending_cmds.push_back(c);
  endtask

  function automatic fifo_cmd_t random_cmd(int unsigned write_pct);
    fifo_cmd_t   c;
    int unsigned r;
    c.data = BYTE_W'($urandom_range(0, 255));
    r      = $urandom_range(0, 99);
    if (r < 65)      c.len = LEN_W'($urandom_range(0, 6));
    else if (r < 85) c.len = LEN_W'($urandom_range(7, 24));
    else if (r < 93) c.len = LEN_W'(DEPTH_DEFAULT);
    else             c.len = LEN_W'($urandom_range(65, LEN_MAX));
    r = $urandom_range(0, 99);
    if (r < write_pct) begin
      c.act = ACT_WRITE;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40)      c.act = ACT_READ;
      else if (r < 65) c.act = ACT_PEEK;
      else if (r < 88) c.act = ACT_POP;
      else             c.act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    end
    return c;
  endfunction

  task automatic queue_random(int unsigned count, int unsigned write_pct);
    int unsigned k;
    for (k = 0; k < count; k++) pending_cmds.push_back(random_cmd(write_pct));
  endtask

  // Sample at the falling edge, when driver and monitor are settled.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_cmds.size() != 0 || push || due_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic set_capacity(logic [CNT_W-1:0] v);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_cap  = v;
    cfg_writes++;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned k;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_capacity(CAP_RESET);
    queue_cmd(ACT_READ, 8'h00, 7'd5);
    queue_cmd(ACT_PEEK, 8'h00, 7'd0);
    queue_cmd(ACT_POP, 8'h00, LEN_MAX);
    queue_cmd(ACT_WRITE, 8'h00, 7'd0);
    queue_cmd(ACT_WRITE, 8'hFF, LEN_MAX);
    queue_cmd(ACT_WRITE, 8'hA5, 7'd3);
    queue_cmd(ACT_WRITE, 8'h5A, 7'd0);
    queue_cmd(ACT_PEEK, 8'h00, 7'd64);
    queue_cmd(ACT_READ, 8'h00, 7'd0);
    queue_cmd(ACT_READ, 8'hFF, 7'd1);
    queue_cmd(ACT_PEEK, 8'h00, 7'd2);
    queue_cmd(ACT_POP, 8'h00, 7'd1);
    queue_cmd(ACT_SPARE_LO, 8'hFF, LEN_MAX);
    queue_cmd(ACT_SPARE_HI, 8'h00, 7'd0);
    queue_cmd(ACT_READ, 8'h00, LEN_MAX);
    queue_cmd(ACT_WRITE, 8'h3C, 7'd0);
    queue_cmd(ACT_POP, 8'h00, 7'd0);
    queue_cmd(ACT_PEEK, 8'h00, 7'd1);
    queue_cmd(ACT_READ, 8'h00, 7'd64);

    // one-byte capacity: second write bounces
    set_capacity(7'd1);
    queue_cmd(ACT_WRITE, 8'h81, 7'd0);
    queue_cmd(ACT_WRITE, 8'h7E, 7'd0);
    queue_cmd(ACT_PEEK, 8'h00, 7'd1);
    queue_cmd(ACT_READ, 8'h00, 7'd1);

    // zero capacity refuses everything
    set_capacity(7'd0);
    queue_cmd(ACT_WRITE, 8'h11, 7'd0);
    queue_cmd(ACT_READ, 8'h00, 7'd3);

    // out-of-range capacity saturates at depth: last writes bounce
    set_capacity(LEN_MAX);
    for (k = 0; k < 70; k++) begin
      queue_cmd(ACT_WRITE, BYTE_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 127)));
    end

    // lower capacity below fill: no drop, no space until fill falls
    set_capacity(7'd10);
    queue_cmd(ACT_WRITE, BYTE_W'($urandom_range(0, 255)), 7'd0);
    queue_cmd(ACT_POP, 8'h00, 7'd58);
    queue_cmd(ACT_WRITE, BYTE_W'($urandom_range(0, 255)), 7'd0);
    queue_cmd(ACT_WRITE, BYTE_W'($urandom_range(0, 255)), 7'd0);
    queue_cmd(ACT_PEEK, 8'h00, 7'd3);
    queue_random(30, 45);

    // full depth with a long receiver stall to back up the input
    set_capacity(CAP_RESET);
    squeeze_req = 1'b1;
    queue_random(60, 55);

    // mid-size capacity, no idling on either side
    set_capacity(CNT_W'($urandom_range(2, 63)));
    burst_mode = 1'b1;
    queue_random(60, 50);

    set_capacity(7'd2);
    burst_mode = 1'b0;
    queue_random(40, 50);

    set_capacity(CNT_W'($urandom_range(0, 127)));
    queue_random(40, 55);

    // close input, then drain what is left
    set_capacity(CAP_RESET);
    queue_random(20, 70);
    queue_cmd(ACT_END, 8'h00, 7'd0);
    queue_cmd(ACT_END, 8'hFF, LEN_MAX);
    queue_cmd(ACT_WRITE, 8'hC3, 7'd0);
    queue_cmd(ACT_PEEK, 8'h00, 7'd3);
    queue_random(10, 20);
    queue_cmd(ACT_READ, 8'h00, 7'd64);
    queue_cmd(ACT_READ, 8'h00, 7'd1);
    queue_cmd(ACT_POP, 8'h00, 7'd5);
    queue_cmd(ACT_SPARE_HI, 8'h00, 7'd0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d commands and %0d results (%0d data bytes) over %0d capacity",
             cmds_taken, results_seen, bytes_seen, cfg_writes);
    $display("settings, including a %0d-cycle result stall and end of input.",
             SQUEEZE_CYCLES);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[flow_controlled_byte_fifo.f]
sv/fcbf_pkg.sv
sv/fcbf_front.sv
sv/fcbf_back.sv
sv/fcbf_res_queue.sv
sv/flow_controlled_byte_fifo.sv
verif/tb_flow_controlled_byte_fifo.sv
